// ===== rtl/apq_pkg.sv =====
// Shared codes and types for the array priority queue.
`timescale 1ns / 1ps

package apq_pkg;

    // Request kinds carried in the slave-side tuser
    typedef logic [1:0] req_t;
    localparam req_t REQ_ENQ  = 2'd0;
    localparam req_t REQ_DEQ  = 2'd1;
    localparam req_t REQ_PEEK = 2'd2;

    // Result status carried in the master-side tuser
    typedef logic [1:0] status_t;
    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_FULL  = 2'd1;
    localparam status_t STAT_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_EMIT
    } apq_state_t;

endpackage

// ===== rtl/apq_mem.sv =====
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module apq_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/array_priority_queue.sv =====
// Top level of the array priority queue: request sequencer, top tracking and result register.
`timescale 1ns / 1ps
//
// Usage
//   Requests enter on the slave-side stream (s_*): s_tuser selects enqueue, dequeue
//   or peek; s_tdata carries the data word and its priority. Every request yields
//   exactly one transaction on the master-side stream (m_*) with the removed or
//   peeked entry, the new top entry, the fill count and a status code.
//   Entries live in one simple dual-port memory in arrival order. The current top
//   entry and its index are held in registers, so enqueue and peek finish at once.
//   From acceptance to a result offered on m_*, enqueue, peek and refused or
//   unknown requests pass straight to S_EMIT; a dequeue first passes S_SCAN,
//   where the one memory read port walks every entry once, moving the tail
//   down by one slot and choosing the new top in the same pass, then S_FINISH.
//   One request is in work at a time; s_tready is high only while the sequencer is
//   idle, and it stays high while a finished result waits in the output register.
//   If m_tready is low, the next result is held until the output register frees.
//   Reset clears the fill count, the top entry and both handshakes; the memory is
//   not cleared, since only slots below the fill count are ever read.
//

module array_priority_queue #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32,
    parameter int RANK_BITS  = 32
) (
    input  logic clk,
    input  logic rst_n,
    // slave side
    input  logic s_tvalid,
    output logic s_tready,
    // item_value, item_rank
    input  logic [((VALUE_BITS+RANK_BITS+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [1:0] s_tuser,
    // master side
    output logic m_tvalid,
    input  logic m_tready,
    // taken_value, taken_rank, top_valid, top_value, top_rank, fill_count
    output logic [((2*VALUE_BITS+2*RANK_BITS+1+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    output logic [1:0] m_tuser
);

    import apq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH+1);
    localparam int EW    = VALUE_BITS + RANK_BITS;
    localparam int OUT_W = ((2*VALUE_BITS+2*RANK_BITS+1+CW+7)/8)*8;

    // Entry a beats entry b: higher rank, or equal rank and larger value
    function automatic logic beats(
        input logic signed [RANK_BITS-1:0]  a_rank,
        input logic signed [VALUE_BITS-1:0] a_value,
        input logic signed [RANK_BITS-1:0]  b_rank,
        input logic signed [VALUE_BITS-1:0] b_value
    );
        beats = (a_rank > b_rank) || ((a_rank == b_rank) && (a_value > b_value));
    endfunction

    apq_state_t state_reg, state_next;

    logic [CW-1:0]                count_reg, count_next;
    logic                         top_valid_reg, top_valid_next;
    logic [AW-1:0]                top_idx_reg, top_idx_next;
    logic signed [VALUE_BITS-1:0] top_value_reg, top_value_next;
    logic signed [RANK_BITS-1:0]  top_rank_reg, top_rank_next;

    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [CW-1:0] scan_end_reg, scan_end_next;
    logic [AW-1:0] pick_reg, pick_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;

    logic                         best_valid_reg, best_valid_next;
    logic [AW-1:0]                best_idx_reg, best_idx_next;
    logic signed [VALUE_BITS-1:0] best_value_reg, best_value_next;
    logic signed [RANK_BITS-1:0]  best_rank_reg, best_rank_next;

    logic signed [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic signed [RANK_BITS-1:0]  res_rank_reg, res_rank_next;
    status_t                      res_status_reg, res_status_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;
    status_t          m_tuser_reg, m_tuser_next;

    // memory interface
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic                         accept;
    req_t                         req;
    logic signed [VALUE_BITS-1:0] in_value;
    logic signed [RANK_BITS-1:0]  in_rank;
    logic signed [VALUE_BITS-1:0] rd_value;
    logic signed [RANK_BITS-1:0]  rd_rank;
    logic                         rd_moves;
    logic [AW-1:0]                rd_new_idx;
    logic signed [VALUE_BITS-1:0] out_top_value;
    logic signed [RANK_BITS-1:0]  out_top_rank;

    apq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign req      = s_tuser;
    assign in_value = $signed(s_tdata[VALUE_BITS-1:0]);
    assign in_rank  = $signed(s_tdata[EW-1:VALUE_BITS]);

    assign rd_value   = $signed(mem_rdata[VALUE_BITS-1:0]);
    assign rd_rank    = $signed(mem_rdata[EW-1:VALUE_BITS]);
    assign rd_moves   = (rd_idx_reg > pick_reg);
    assign rd_new_idx = rd_moves ? (rd_idx_reg - AW'(1)) : rd_idx_reg;

    assign out_top_value = top_valid_reg ? top_value_reg : '0;
    assign out_top_rank  = top_valid_reg ? top_rank_reg  : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            top_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            top_valid_reg  <= top_valid_next;
            rd_valid_reg   <= rd_valid_next;
            best_valid_reg <= best_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_idx_reg    <= top_idx_next;
        top_value_reg  <= top_value_next;
        top_rank_reg   <= top_rank_next;
        scan_idx_reg   <= scan_idx_next;
        scan_end_reg   <= scan_end_next;
        pick_reg       <= pick_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_value_reg <= best_value_next;
        best_rank_reg  <= best_rank_next;
        res_value_reg  <= res_value_next;
        res_rank_reg   <= res_rank_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        top_valid_next  = top_valid_reg;
        top_idx_next    = top_idx_reg;
        top_value_next  = top_value_reg;
        top_rank_next   = top_rank_reg;
        scan_idx_next   = scan_idx_reg;
        scan_end_next   = scan_end_reg;
        pick_next       = pick_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        best_valid_next = best_valid_reg;
        best_idx_next   = best_idx_reg;
        best_value_next = best_value_reg;
        best_rank_next  = best_rank_reg;
        res_value_next  = res_value_reg;
        res_rank_next   = res_rank_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_new_idx;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;
        mem_raddr       = scan_idx_reg[AW-1:0];

        // scan stage: read data back, move it down past the removed slot, track best
        if (rd_valid_reg)
        begin
            mem_we = rd_moves;
            if (!best_valid_reg || beats(rd_rank, rd_value, best_rank_reg, best_value_reg))
            begin
                best_valid_next = 1'b1;
                best_idx_next   = rd_new_idx;
                best_value_next = rd_value;
                best_rank_next  = rd_rank;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_rank_next   = '0;
                    res_status_next = STAT_OK;
                    state_next      = S_EMIT;
                    case (req)
                        REQ_ENQ:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = {in_rank, in_value};
                                count_next = count_reg + CW'(1);
                                if (!top_valid_reg ||
                                    beats(in_rank, in_value, top_rank_reg, top_value_reg))
                                begin
                                    top_valid_next = 1'b1;
                                    top_idx_next   = count_reg[AW-1:0];
                                    top_value_next = in_value;
                                    top_rank_next  = in_rank;
                                end
                            end
                        end
                        REQ_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                res_value_next  = top_value_reg;
                                res_rank_next   = top_rank_reg;
                                pick_next       = top_idx_reg;
                                scan_end_next   = count_reg;
                                scan_idx_next   = '0;
                                count_next      = count_reg - CW'(1);
                                best_valid_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        REQ_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                res_value_next = top_value_reg;
                                res_rank_next  = top_rank_reg;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue one read per cycle over the old entries; the removed one is read but not used
                if (scan_idx_reg != scan_end_reg)
                begin
                    mem_re        = 1'b1;
                    rd_valid_next = (scan_idx_reg[AW-1:0] != pick_reg);
                    rd_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                top_valid_next = best_valid_reg;
                top_idx_next   = best_idx_reg;
                top_value_next = best_value_reg;
                top_rank_next  = best_rank_reg;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({count_reg, out_top_rank, out_top_value,
                                            top_valid_reg, res_rank_reg, res_value_reg});
                    m_tuser_next  = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/apq_checker.sv =====
// Port-level checks for the array priority queue, bound to the top level.
`timescale 1ns / 1ps

module apq_checker #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32,
    parameter int RANK_BITS  = 32
) (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [((2*VALUE_BITS+2*RANK_BITS+1+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    input logic [1:0] m_tuser
);

    import apq_pkg::*;

    localparam int CW      = $clog2(DEPTH+1);
    localparam int OFS_TR  = VALUE_BITS;
    localparam int OFS_TV  = VALUE_BITS + RANK_BITS;
    localparam int OFS_CNT = 2*VALUE_BITS + 2*RANK_BITS + 1;

    logic [CW-1:0]         fill;
    logic                  top_valid;
    logic [VALUE_BITS-1:0] taken_value;
    logic [RANK_BITS-1:0]  taken_rank;

    assign fill        = m_tdata[OFS_CNT +: CW];
    assign top_valid   = m_tdata[OFS_TV];
    assign taken_value = m_tdata[VALUE_BITS-1:0];
    assign taken_rank  = m_tdata[OFS_TR +: RANK_BITS];

    // a stalled result transaction holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // top entry reported exactly when the queue is not empty
    a_top_vs_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (top_valid == (fill != '0)))
        else $error("top_valid disagrees with fill count");

    // empty refusal leaves an empty queue and zero taken fields
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_EMPTY) |->
            (fill == '0) && (taken_value == '0) && (taken_rank == '0))
        else $error("empty status with entries or taken data");

    // full refusal only at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_FULL) |-> (fill == CW'(DEPTH)))
        else $error("full status below capacity");

    // one request at a time: the input closes after each accepted transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while busy");

endmodule

bind array_priority_queue apq_checker #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .RANK_BITS  (RANK_BITS)
) u_apq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== test/array_priority_queue_checker.sv =====
// Scoreboard for the array priority queue: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module array_priority_queue_checker #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32,
    parameter int RANK_BITS  = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  logic s_tready,
    // item_value, item_rank
    input  logic [((VALUE_BITS+RANK_BITS+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [1:0] s_tuser,
    input  logic m_tvalid,
    input  logic m_tready,
    // taken_value, taken_rank, top_valid, top_value, top_rank, fill_count
    input  logic [((2*VALUE_BITS+2*RANK_BITS+1+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // status
    input  logic [1:0] m_tuser,
    output int mismatches,
    output int outstanding
);

    import apq_pkg::*;

    localparam int COUNT_BITS    = $clog2(DEPTH + 1);
    localparam int TAKEN_RANK_LO = VALUE_BITS;
    localparam int TOP_VALID_BIT = VALUE_BITS + RANK_BITS;
    localparam int TOP_VALUE_LO  = TOP_VALID_BIT + 1;
    localparam int TOP_RANK_LO   = TOP_VALUE_LO + VALUE_BITS;
    localparam int FILL_LO       = TOP_RANK_LO + RANK_BITS;

    typedef struct {
        logic [VALUE_BITS-1:0] taken_value;
        logic [RANK_BITS-1:0]  taken_rank;
        logic                  top_valid;
        logic [VALUE_BITS-1:0] top_value;
        logic [RANK_BITS-1:0]  top_rank;
        logic [COUNT_BITS-1:0] fill_count;
        status_t               status;
    } queue_outcome_t;

    // Shadow copy of the stored entries, kept in arrival order
    logic signed [VALUE_BITS-1:0] shadow_value [DEPTH];
    logic signed [RANK_BITS-1:0]  shadow_rank  [DEPTH];
    int                           shadow_count;
    queue_outcome_t               awaited_outcomes [$];

    // Highest rank wins, then larger value, then earliest arrival
    function automatic int winning_slot();
        int best;
        best = 0;
        for (int i = 1; i < shadow_count; i++)
            if (shadow_rank[i] > shadow_rank[best] ||
                (shadow_rank[i] == shadow_rank[best] && shadow_value[i] > shadow_value[best]))
                best = i;
        return best;
    endfunction

    // Applies one request to the shadow queue and returns the result it should produce
    function automatic queue_outcome_t serve_request(input req_t kind,
                                                     input logic [VALUE_BITS-1:0] value,
                                                     input logic [RANK_BITS-1:0] rank);
        queue_outcome_t outcome;
        int pick;
        outcome.taken_value = '0;
        outcome.taken_rank  = '0;
        outcome.top_valid   = 1'b0;
        outcome.top_value   = '0;
        outcome.top_rank    = '0;
        outcome.status      = STAT_OK;
        if (kind == REQ_ENQ) begin
            if (shadow_count >= DEPTH)
                outcome.status = STAT_FULL;
            else
            begin
                shadow_value[shadow_count] = value;
                shadow_rank[shadow_count]  = rank;
                shadow_count++;
            end
        end
        else if (kind == REQ_DEQ || kind == REQ_PEEK) begin
            if (shadow_count == 0)
                outcome.status = STAT_EMPTY;
            else
            begin
                pick = winning_slot();
                outcome.taken_value = shadow_value[pick];
                outcome.taken_rank  = shadow_rank[pick];
                // dequeue closes the gap behind the removed entry
                if (kind == REQ_DEQ) begin
                    for (int i = pick; i < shadow_count - 1; i++) begin
                        shadow_value[i] = shadow_value[i+1];
                        shadow_rank[i]  = shadow_rank[i+1];
                    end
                    shadow_count--;
                end
            end
        end
        if (shadow_count > 0) begin
            pick = winning_slot();
            outcome.top_valid = 1'b1;
            outcome.top_value = shadow_value[pick];
            outcome.top_rank  = shadow_rank[pick];
        end
        outcome.fill_count = COUNT_BITS'(shadow_count);
        return outcome;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: queue result mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    // Results are checked before the request of the same edge is applied
    always @(posedge clk or negedge rst_n) begin : monitor
        queue_outcome_t seen;
        queue_outcome_t want;
        if (!rst_n) begin
            shadow_count = 0;
            awaited_outcomes.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready) begin
                seen.taken_value = m_tdata[VALUE_BITS-1:0];
                seen.taken_rank  = m_tdata[TAKEN_RANK_LO +: RANK_BITS];
                seen.top_valid   = m_tdata[TOP_VALID_BIT];
                seen.top_value   = m_tdata[TOP_VALUE_LO +: VALUE_BITS];
                seen.top_rank    = m_tdata[TOP_RANK_LO +: RANK_BITS];
                seen.fill_count  = m_tdata[FILL_LO +: COUNT_BITS];
                seen.status      = m_tuser;
                if (awaited_outcomes.size() == 0)
                    report_mismatch("result transaction with no request waiting");
                else
                begin
                    want = awaited_outcomes.pop_front();
                    check_field("taken_value", 64'(seen.taken_value), 64'(want.taken_value));
                    check_field("taken_rank", 64'(seen.taken_rank), 64'(want.taken_rank));
                    check_field("top_valid", 64'(seen.top_valid), 64'(want.top_valid));
                    check_field("top_value", 64'(seen.top_value), 64'(want.top_value));
                    check_field("top_rank", 64'(seen.top_rank), 64'(want.top_rank));
                    check_field("fill_count", 64'(seen.fill_count), 64'(want.fill_count));
                    check_field("status", 64'(seen.status), 64'(want.status));
                end
            end
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(serve_request(s_tuser, s_tdata[VALUE_BITS-1:0],
                                                         s_tdata[VALUE_BITS +: RANK_BITS]));
            outstanding = awaited_outcomes.size();
        end
    end

endmodule

// ===== test/array_priority_queue_test.sv =====
// Testbench top for the array priority queue: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module array_priority_queue_test;

    import apq_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int VALUE_BITS    = 32;
    localparam int RANK_BITS     = 32;
    localparam int S_BITS        = ((VALUE_BITS + RANK_BITS + 7) / 8) * 8;
    localparam int M_BITS        = ((2*VALUE_BITS + 2*RANK_BITS + 1 + $clog2(DEPTH+1) + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 580;
    localparam int SHALLOW_LEVEL = 24;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 60;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 20000;

    // request code the block does not know; it must be ignored
    localparam req_t REQ_SPARE = 2'd3;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_BITS-1:0] s_tdata  = '0;
    logic [1:0]        s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [M_BITS-1:0] m_tdata;
    logic [1:0]        m_tuser;
    int                mismatches;
    int                outstanding;

    // stimulus bookkeeping: expected fill level and number of real requests sent
    int level = 0;
    int requests_made = 0;
    int sender_calm = 0;

    array_priority_queue #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .RANK_BITS  (RANK_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    array_priority_queue_checker #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .RANK_BITS  (RANK_BITS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly no gap, often short, now and then long
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    // Small pool for ties, the extremes, otherwise any word
    function automatic logic [31:0] draw_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return 32'(int'($urandom_range(0, 6)) - 3);
        else if (roll < 40)
            return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
        else
            return $urandom();
    endfunction

    // Offers one request transaction after a random gap and waits for acceptance
    task automatic issue(input req_t kind, input logic [31:0] value, input logic [31:0] rank);
        int gap;
        if (sender_calm > 0) begin
            sender_calm--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                sender_calm = $urandom_range(15, 50);
            gap = draw_gap();
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_BITS'({rank, value});
        do @(posedge clk); while (!(s_tvalid && s_tready));
        if (kind == REQ_ENQ && level < DEPTH)
            level++;
        else if (kind == REQ_DEQ && level > 0)
            level--;
        if (kind != REQ_SPARE)
            requests_made++;
    endtask

    // Result side: random back-pressure, one long hold-off after HOLD_AFTER results
    initial
    begin : result_sink
        int gap;
        int taken;
        int calm;
        bit held;
        taken = 0;
        calm = 0;
        held = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                gap = LONG_HOLD;
            end
            else if (calm > 0) begin
                calm--;
                gap = 0;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    calm = $urandom_range(15, 50);
                gap = draw_gap();
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    // Ends the run when no transaction moves for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        do @(posedge clk); while (!rst_n);
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("array_priority_queue_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int target;
        int roll;
        int enq_pct;
        req_t kind;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, minimum and maximum ranks, ties, ignored code
        issue(REQ_DEQ, 32'h1234_5678, 32'h0000_0001);
        issue(REQ_PEEK, 32'hffff_ffff, 32'hffff_ffff);
        issue(REQ_SPARE, $urandom(), $urandom());
        issue(REQ_ENQ, 32'h7fff_ffff, 32'h8000_0000);
        issue(REQ_PEEK, 32'h0, 32'h0);
        issue(REQ_ENQ, 32'h8000_0000, 32'h8000_0000);
        issue(REQ_PEEK, 32'h0, 32'h0);
        issue(REQ_ENQ, 32'h0000_0005, 32'h7fff_ffff);
        issue(REQ_ENQ, 32'h0000_0005, 32'h7fff_ffff);
        issue(REQ_ENQ, 32'h0000_0006, 32'h7fff_ffff);
        issue(REQ_SPARE, $urandom(), $urandom());
        issue(REQ_DEQ, 32'h0, 32'h0);
        issue(REQ_DEQ, 32'h0, 32'h0);
        issue(REQ_ENQ, 32'hffff_ffff, 32'hffff_ffff);
        issue(REQ_ENQ, 32'h0000_0000, 32'h0000_0000);
        issue(REQ_DEQ, 32'h0, 32'h0);
        issue(REQ_DEQ, 32'h0, 32'h0);
        issue(REQ_DEQ, 32'h0, 32'h0);
        issue(REQ_DEQ, 32'h0, 32'h0);
        issue(REQ_DEQ, 32'h0, 32'h0);
        issue(REQ_DEQ, 32'h0, 32'h0);

        // random mix kept shallow so dequeues stay quick
        target = requests_made + RANDOM_ITEMS;
        while (requests_made < target) begin
            roll = $urandom_range(0, 99);
            if (level == 0)
                enq_pct = 70;
            else if (level >= SHALLOW_LEVEL)
                enq_pct = 25;
            else
                enq_pct = 48;
            if (roll < 4)
                kind = REQ_SPARE;
            else if (roll < 4 + enq_pct)
                kind = REQ_ENQ;
            else if ($urandom_range(0, 9) < 6)
                kind = REQ_DEQ;
            else
                kind = REQ_PEEK;
            issue(kind, draw_word(), draw_word());
        end

        // fill to capacity, then refusals and operations on a full queue
        while (level < DEPTH)
            issue(REQ_ENQ, draw_word(), draw_word());
        issue(REQ_ENQ, draw_word(), draw_word());
        issue(REQ_ENQ, 32'h7fff_ffff, 32'h7fff_ffff);
        issue(REQ_PEEK, draw_word(), draw_word());
        issue(REQ_SPARE, draw_word(), draw_word());
        issue(REQ_DEQ, draw_word(), draw_word());
        issue(REQ_ENQ, 32'h8000_0000, 32'h8000_0000);
        issue(REQ_ENQ, draw_word(), draw_word());
        issue(REQ_DEQ, draw_word(), draw_word());
        issue(REQ_PEEK, draw_word(), draw_word());
        s_tvalid <= 1'b0;

        // wait for every result, then a quiet tail for strays
        do @(negedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("array_priority_queue_test: done, clean");
        else
            $display("array_priority_queue_test: done, errors");
        $finish;
    end

endmodule
